// ===== rtl/slgn_pkg.sv =====
// shared constants, op codes and controller/datapath structs for the gaussian noise source
package slgn_pkg;

   localparam int AMPLITUDE_MAX = 2047;
   localparam int SHUFFLE_DEPTH = 100;

   localparam int CDF_DEPTH = AMPLITUDE_MAX + 2;
   localparam int CDF_AW    = $clog2(CDF_DEPTH);
   localparam int HI_W      = $clog2(CDF_DEPTH + 1);
   localparam int SLOT_W    = $clog2(SHUFFLE_DEPTH);
   localparam int CNT_W     = $clog2(2 * SHUFFLE_DEPTH + 1);

   localparam int WORD_W   = 21;
   localparam int INDEX_W  = 12;
   localparam int SAMPLE_W = 12;
   localparam int OP_W     = 2;

   localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OP_W-1:0] OP_INIT = 2'd1;
   localparam logic [OP_W-1:0] OP_GEN  = 2'd2;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_SEED = 1'd0;

   localparam logic [11:0]     LCG_MUL  = 12'd2416;
   localparam logic [32:0]     LCG_ADD  = 33'd374441;
   localparam logic [WORD_W-1:0] LCG_MOD  = 21'd1771875;
   localparam logic [22:0]     LCG_MOD2 = 23'd3543750;
   localparam logic [WORD_W-1:0] RAND_TOP = 21'd1771874;

   // reciprocals for the constant divisions
   localparam logic [14:0] LCG_RECIP  = 15'((64'd1 << 35) / 64'd1771875);
   localparam logic [13:0] SLOT_RECIP = 14'((64'd1 << 34) / 64'd1771874);

   localparam int V_W  = WORD_W + SLOT_W;
   localparam int SP_W = V_W + 14;
   localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SHUFFLE_DEPTH - 1);

   typedef struct packed {
      logic req_ready;
      logic capture;
      logic cdf_write;
      logic seed_load;
      logic step_start;
      logic init_cnt_inc;
      logic shuffle_fill;
      logic shuffle_swap;
      logic shuffle_ready_set;
      logic search_start;
      logic search_probe;
      logic rsp_load;
      logic rsp_is_sample;
      logic rsp_refused;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            cdf_ready;
      logic            shuffle_ready;
      logic            step_done;
      logic            init_last;
      logic            search_done;
   } dp_status_type;

endpackage

// ===== rtl/shuffled_lcg_gaussian_noise_top.sv =====
// top level of the shuffled lcg gaussian noise source: csr port, stream ports, output register
//
// req channel: one word per operation. tuser carries the op (load cdf entry, init, generate);
// tdata carries the cdf entry index and value for a load.
// rsp channel: exactly one word per request word, in order. tdata carries the signed sample
// (zero unless a generate succeeds); tuser carries the status flag (set when generate is
// refused because the cdf table or the shuffle table is not ready).
// csr port: seed register at byte address 0; write only while the block is idle (not enforced).
// timing: a load or refused/unused op passes through dispatch and finish to its result. a
// generate runs one pass of the generator step pipeline, a shuffle table swap, then one
// cdf memory probe per cycle for the binary search.
// an init runs 201 sequential generator steps.
// one operation is in progress at a time; a new word is taken as soon as the previous
// result sits in the output register.
// reset clears the generator value, both ready flags and the seed; the cdf and shuffle
// tables keep whatever they hold until loaded or initialized.
// when the receiver stalls, the result holds in the output register, the block finishes
// the next operation and then waits with req_tready low until the register drains.
module shuffled_lcg_gaussian_noise_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // entry_index[11:0], entry_value[32:12], zero pad
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // sample[11:0], zero pad
   output logic        rsp_tuser,  // status[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [slgn_pkg::WORD_W-1:0]   seed_ff, seed_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [slgn_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic                          rsp_status_ff;
   logic                          csr_sel_seed;
   logic                          out_free;
   logic [slgn_pkg::SAMPLE_W-1:0] dp_sample;

   slgn_pkg::ctrl_cmd_type  cmd;
   slgn_pkg::dp_status_type status;

   assign csr_pready   = 1'b1;
   assign csr_sel_seed = csr_paddr[2] == slgn_pkg::REG_SEED;
   assign csr_prdata   = csr_sel_seed ? 32'(seed_ff) : 32'd0;

   always_comb begin
      seed_in = seed_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_seed) begin
         seed_in = csr_pwdata[slgn_pkg::WORD_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_sample_ff <= cmd.rsp_is_sample ? dp_sample : '0;
         rsp_status_ff <= cmd.rsp_refused;
      end
   end

   slgn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   slgn_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_op    (req_tuser),
      .in_index (req_tdata[11:0]),
      .in_value (req_tdata[32:12]),
      .seed     (seed_ff),
      .status   (status),
      .sample   (dp_sample)
   );

   assign req_tready = cmd.req_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_sample_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/slgn_lcg.sv =====
// generator step unit: next lcg value and shuffle slot, five-stage multi-cycle pipeline
module slgn_lcg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              seed_load,
   input  logic [slgn_pkg::WORD_W-1:0]       seed,
   input  logic                              step_start,
   output logic [slgn_pkg::WORD_W-1:0]       gen_value,
   output logic [slgn_pkg::SLOT_W-1:0]       slot,
   output logic                              step_done
);

   logic [4:0]                        vld_ff, vld_in;
   logic [slgn_pkg::WORD_W-1:0]       g_ff, g_in;
   logic [slgn_pkg::SLOT_W-1:0]       slot_ff;

   logic [32:0]                       p1_ff, p2_ff, p3_ff, m3_ff;
   logic [11:0]                       q2_ff;
   logic [22:0]                       r4_ff;
   logic [slgn_pkg::V_W-1:0]          v1_ff, v2_ff, v3_ff, sm3_ff;
   logic [slgn_pkg::SLOT_W-1:0]       sq2_ff, sq3_ff, sq4_ff;

   logic [36:0]                       q_prod;
   logic [slgn_pkg::SP_W-1:0]         s_prod;
   logic [32:0]                       r_diff;
   logic [slgn_pkg::V_W-1:0]          s_diff;
   logic [slgn_pkg::WORD_W-1:0]       g_red;

   assign q_prod = 37'(p1_ff[32:11]) * 37'(slgn_pkg::LCG_RECIP);
   assign s_prod = slgn_pkg::SP_W'(v2_ff) * slgn_pkg::SP_W'(slgn_pkg::SLOT_RECIP);
   assign r_diff = p3_ff - m3_ff;
   assign s_diff = v3_ff - sm3_ff;

   always_comb begin
      if (r4_ff >= slgn_pkg::LCG_MOD2) begin
         g_red = slgn_pkg::WORD_W'(r4_ff - slgn_pkg::LCG_MOD2);
      end else if (r4_ff >= 23'(slgn_pkg::LCG_MOD)) begin
         g_red = slgn_pkg::WORD_W'(r4_ff - 23'(slgn_pkg::LCG_MOD));
      end else begin
         g_red = slgn_pkg::WORD_W'(r4_ff);
      end
   end

   always_comb begin
      vld_in = {vld_ff[3:0], step_start};
      if (seed_load) begin
         g_in = seed;
      end else if (vld_ff[3]) begin
         g_in = g_red;
      end else begin
         g_in = g_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         g_ff   <= '0;
      end else begin
         vld_ff <= vld_in;
         g_ff   <= g_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= 33'(g_ff) * 33'(slgn_pkg::LCG_MUL) + slgn_pkg::LCG_ADD;
      v1_ff  <= slgn_pkg::V_W'(g_ff) * slgn_pkg::V_W'(slgn_pkg::SLOT_MAX);
      q2_ff  <= q_prod[35:24];
      p2_ff  <= p1_ff;
      sq2_ff <= s_prod[34 +: slgn_pkg::SLOT_W];
      v2_ff  <= v1_ff;
      m3_ff  <= 33'(q2_ff) * 33'(slgn_pkg::LCG_MOD);
      p3_ff  <= p2_ff;
      sm3_ff <= slgn_pkg::V_W'(sq2_ff) * slgn_pkg::V_W'(slgn_pkg::RAND_TOP);
      sq3_ff <= sq2_ff;
      v3_ff  <= v2_ff;
      r4_ff  <= r_diff[22:0];
      sq4_ff <= sq3_ff + slgn_pkg::SLOT_W'(s_diff >= slgn_pkg::V_W'(slgn_pkg::RAND_TOP));
      if (vld_ff[3]) begin
         slot_ff <= (sq4_ff > slgn_pkg::SLOT_MAX) ? slgn_pkg::SLOT_MAX : sq4_ff;
      end
   end

   assign gen_value = g_ff;
   assign slot      = slot_ff;
   assign step_done = vld_ff[4];

endmodule

// ===== rtl/slgn_datapath.sv =====
// datapath: input capture, cdf and shuffle memories, generator unit and binary search
module slgn_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  slgn_pkg::ctrl_cmd_type            cmd,
   input  logic [slgn_pkg::OP_W-1:0]         in_op,
   input  logic [slgn_pkg::INDEX_W-1:0]      in_index,
   input  logic [slgn_pkg::WORD_W-1:0]       in_value,
   input  logic [slgn_pkg::WORD_W-1:0]       seed,
   output slgn_pkg::dp_status_type           status,
   output logic [slgn_pkg::SAMPLE_W-1:0]     sample
);

   logic [slgn_pkg::OP_W-1:0]     op_ff;
   logic [slgn_pkg::INDEX_W-1:0]  idx_ff;
   logic [slgn_pkg::WORD_W-1:0]   val_ff;
   logic                          cdf_ready_ff, cdf_ready_in;
   logic                          shuffle_ready_ff, shuffle_ready_in;
   logic [slgn_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [slgn_pkg::WORD_W-1:0]   target_ff;
   logic [slgn_pkg::WORD_W-1:0]   cdf_q_ff;
   logic [slgn_pkg::HI_W-1:0]     lo_ff, hi_ff;
   logic [slgn_pkg::CDF_AW-1:0]   mid_ff;

   logic [slgn_pkg::WORD_W-1:0]   cdf_mem [slgn_pkg::CDF_DEPTH];
   logic [slgn_pkg::WORD_W-1:0]   sh_mem  [slgn_pkg::SHUFFLE_DEPTH];

   logic [slgn_pkg::WORD_W-1:0]   gen_value;
   logic [slgn_pkg::SLOT_W-1:0]   slot;
   logic                          step_done;

   logic                          idx_ok, idx_last;
   logic                          init_fill;
   logic [slgn_pkg::SLOT_W-1:0]   fill_addr, sh_wa;
   logic                          sh_we;
   logic                          gt;
   logic [slgn_pkg::HI_W-1:0]     lo_n, hi_n, span;
   logic [slgn_pkg::HI_W:0]       mid_sum;
   logic [slgn_pkg::CDF_AW-1:0]   mid_in, rd_addr;
   logic                          rd_en;
   logic [slgn_pkg::SAMPLE_W-1:0] mag;

   slgn_lcg u_lcg (
      .clock      (clock),
      .reset      (reset),
      .seed_load  (cmd.seed_load),
      .seed       (seed),
      .step_start (cmd.step_start),
      .gen_value  (gen_value),
      .slot       (slot),
      .step_done  (step_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= in_op;
         idx_ff <= in_index;
         val_ff <= in_value;
      end
   end

   assign idx_ok   = int'(idx_ff) < slgn_pkg::CDF_DEPTH;
   assign idx_last = int'(idx_ff) == slgn_pkg::CDF_DEPTH - 1;

   assign init_fill = (cnt_ff >= slgn_pkg::CNT_W'(slgn_pkg::SHUFFLE_DEPTH)) &&
                      (cnt_ff < slgn_pkg::CNT_W'(2 * slgn_pkg::SHUFFLE_DEPTH));
   assign fill_addr = slgn_pkg::SLOT_W'(cnt_ff - slgn_pkg::CNT_W'(slgn_pkg::SHUFFLE_DEPTH));

   always_comb begin
      cdf_ready_in     = cdf_ready_ff | (cmd.cdf_write & idx_ok & idx_last);
      shuffle_ready_in = shuffle_ready_ff | cmd.shuffle_ready_set;
      if (cmd.seed_load) begin
         cnt_in = '0;
      end else if (cmd.init_cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cdf_ready_ff     <= 1'b0;
         shuffle_ready_ff <= 1'b0;
         cnt_ff           <= '0;
      end else begin
         cdf_ready_ff     <= cdf_ready_in;
         shuffle_ready_ff <= shuffle_ready_in;
         cnt_ff           <= cnt_in;
      end
   end

   // shuffle table: one write port, read only on a swap
   assign sh_we = cmd.shuffle_swap | (cmd.shuffle_fill & init_fill);
   assign sh_wa = cmd.shuffle_swap ? slot : fill_addr;

   always_ff @(posedge clock) begin
      if (cmd.shuffle_swap) begin
         target_ff <= sh_mem[slot];
      end
      if (sh_we) begin
         sh_mem[sh_wa] <= gen_value;
      end
   end

   // search step
   assign gt      = target_ff > cdf_q_ff;
   assign lo_n    = gt ? slgn_pkg::HI_W'(mid_ff) : lo_ff;
   assign hi_n    = gt ? hi_ff : slgn_pkg::HI_W'(mid_ff);
   assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
   assign mid_in  = slgn_pkg::CDF_AW'(mid_sum >> 1);
   assign span    = hi_n - lo_n;

   assign rd_en   = cmd.search_start | cmd.search_probe;
   assign rd_addr = cmd.search_start ? slgn_pkg::CDF_AW'(slgn_pkg::CDF_DEPTH >> 1) : mid_in;

   always_ff @(posedge clock) begin
      if (cmd.cdf_write && idx_ok) begin
         cdf_mem[slgn_pkg::CDF_AW'(idx_ff)] <= val_ff;
      end
      if (rd_en) begin
         cdf_q_ff <= cdf_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         lo_ff  <= '0;
         hi_ff  <= slgn_pkg::HI_W'(slgn_pkg::CDF_DEPTH);
         mid_ff <= slgn_pkg::CDF_AW'(slgn_pkg::CDF_DEPTH >> 1);
      end else if (cmd.search_probe) begin
         lo_ff  <= lo_n;
         hi_ff  <= hi_n;
         mid_ff <= mid_in;
      end
   end

   assign mag = (lo_ff > slgn_pkg::HI_W'(slgn_pkg::AMPLITUDE_MAX)) ?
                slgn_pkg::SAMPLE_W'(slgn_pkg::AMPLITUDE_MAX) : slgn_pkg::SAMPLE_W'(lo_ff);
   assign sample = target_ff[0] ? (~mag + 1'b1) : mag;

   assign status.op            = op_ff;
   assign status.cdf_ready     = cdf_ready_ff;
   assign status.shuffle_ready = shuffle_ready_ff;
   assign status.step_done     = step_done;
   assign status.init_last     = cnt_ff == slgn_pkg::CNT_W'(2 * slgn_pkg::SHUFFLE_DEPTH);
   assign status.search_done   = span <= slgn_pkg::HI_W'(1);

endmodule

// ===== rtl/slgn_ctrl.sv =====
// controller state machine sequencing load, init and generate operations
module slgn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    out_free,
   input  slgn_pkg::dp_status_type status,
   output slgn_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE         = 4'd0;
   localparam logic [3:0] S_DISPATCH     = 4'd1;
   localparam logic [3:0] S_INIT_STEP    = 4'd2;
   localparam logic [3:0] S_INIT_WAIT    = 4'd3;
   localparam logic [3:0] S_GEN_STEP     = 4'd4;
   localparam logic [3:0] S_GEN_WAIT     = 4'd5;
   localparam logic [3:0] S_SEARCH_START = 4'd6;
   localparam logic [3:0] S_SEARCH       = 4'd7;
   localparam logic [3:0] S_FINISH       = 4'd8;

   localparam logic [1:0] RES_ZERO    = 2'd0;
   localparam logic [1:0] RES_REFUSED = 2'd1;
   localparam logic [1:0] RES_SAMPLE  = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] res_ff, res_in;

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      cmd      = '0;
      cmd.rsp_is_sample = res_ff == RES_SAMPLE;
      cmd.rsp_refused   = res_ff == RES_REFUSED;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.op)
               slgn_pkg::OP_LOAD: begin
                  cmd.cdf_write = 1'b1;
                  res_in        = RES_ZERO;
                  state_in      = S_FINISH;
               end
               slgn_pkg::OP_INIT: begin
                  cmd.seed_load = 1'b1;
                  state_in      = S_INIT_STEP;
               end
               slgn_pkg::OP_GEN: begin
                  if (status.cdf_ready && status.shuffle_ready) begin
                     state_in = S_GEN_STEP;
                  end else begin
                     res_in   = RES_REFUSED;
                     state_in = S_FINISH;
                  end
               end
               default: begin
                  res_in   = RES_ZERO;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_INIT_STEP: begin
            cmd.step_start = 1'b1;
            state_in       = S_INIT_WAIT;
         end
         S_INIT_WAIT: begin
            if (status.step_done) begin
               cmd.shuffle_fill = 1'b1;
               cmd.init_cnt_inc = 1'b1;
               if (status.init_last) begin
                  cmd.shuffle_ready_set = 1'b1;
                  res_in                = RES_ZERO;
                  state_in              = S_FINISH;
               end else begin
                  state_in = S_INIT_STEP;
               end
            end
         end
         S_GEN_STEP: begin
            cmd.step_start = 1'b1;
            state_in       = S_GEN_WAIT;
         end
         S_GEN_WAIT: begin
            if (status.step_done) begin
               cmd.shuffle_swap = 1'b1;
               state_in         = S_SEARCH_START;
            end
         end
         S_SEARCH_START: begin
            cmd.search_start = 1'b1;
            state_in         = S_SEARCH;
         end
         S_SEARCH: begin
            cmd.search_probe = 1'b1;
            if (status.search_done) begin
               res_in   = RES_SAMPLE;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= RES_ZERO;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

endmodule
